>>> rtl/u8d_pkg.sv
// Shared types, constants and command codes for the lenient UTF-8 decoder.
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int BYTE_W            = 8;
    localparam int CODE_W            = 31;
    localparam int CFG_IDX_W         = 1;
    localparam int QUEUE_DEPTH       = 4;
    localparam int DEF_MAX_SEQ_BYTES = 6;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_CODE_POINT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAD_CHAR_CODE  = 1'd1;

    localparam logic [CODE_W-1:0] RST_MAX_CODE_POINT = 31'h0010_FFFF;
    localparam logic [CODE_W-1:0] RST_BAD_CHAR_CODE  = 31'h0000_FFFD;

    // What the front end issues for one byte
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ASCII,
        OP_EOT,
        OP_BAD,
        OP_VALUE,
        OP_CUT_ASCII,
        OP_CUT_EOT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CODE_W-1:0] data;
    } t_cmd;

endpackage

>>> rtl/u8d_ifs.sv
// Valid/ready channel interfaces: byte input, result output, configuration writes.
`timescale 1ns / 1ps

interface u8d_byte_if;
    import u8d_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;

    modport source (output valid, output byte_value, input ready);
    modport sink   (input valid, input byte_value, output ready);
endinterface

interface u8d_result_if;
    import u8d_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_point;
    logic              is_bad;
    logic              end_of_text;
    logic              last;

    modport source (output valid, output code_point, output is_bad, output end_of_text,
                    output last, input ready);
    modport sink   (input valid, input code_point, input is_bad, input end_of_text,
                    input last, output ready);
endinterface

interface u8d_cfg_if;
    import u8d_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CODE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/u8d_front.sv
// Front end: accepts bytes, tracks the decode phase and issues at most one command per byte.
`timescale 1ns / 1ps

module u8d_front #(
    parameter int MAX_SEQ_BYTES = u8d_pkg::DEF_MAX_SEQ_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    u8d_byte_if.sink                    i_byte,
    input  logic [u8d_pkg::CODE_W-1:0]  i_max_code_point,
    input  logic                        i_full,
    output logic                        o_push,
    output u8d_pkg::t_cmd               o_cmd
);
    import u8d_pkg::*;

    localparam int RW = $clog2(MAX_SEQ_BYTES);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_COLLECT = 2'd1;
    localparam logic [1:0] PH_SKIP    = 2'd2;

    // Sequence length announced by a lead byte, zero when it is no valid lead
    function automatic logic [3:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [3:0] len;
        len = 4'd0;
        if ((b & 8'he0) == 8'hc0)      len = 4'd2;
        else if ((b & 8'hf0) == 8'he0) len = 4'd3;
        else if ((b & 8'hf8) == 8'hf0) len = 4'd4;
        else if ((b & 8'hfc) == 8'hf8) len = 4'd5;
        else if ((b & 8'hfe) == 8'hfc) len = 4'd6;
        return len;
    endfunction

    logic [1:0]        r_phase, n_phase;
    logic [RW-1:0]     r_rem, n_rem;
    logic [CODE_W-1:0] r_acc, n_acc;

    logic              accept;
    logic [BYTE_W-1:0] b;
    logic [3:0]        len;
    logic              lead_ok;
    logic [CODE_W-1:0] acc_shift;
    logic [RW-1:0]     rem_dec;
    t_op               st_op, op;
    logic [1:0]        st_phase;
    logic [RW-1:0]     st_rem;
    logic [CODE_W-1:0] st_acc, data;

    assign accept        = i_byte.valid && !i_full;
    assign i_byte.ready  = !i_full;
    assign b             = i_byte.byte_value;
    assign len           = lead_len(b);
    assign lead_ok       = (len != 4'd0) && (32'(len) <= MAX_SEQ_BYTES);
    assign acc_shift     = {r_acc[CODE_W-7:0], b[5:0]};
    assign rem_dec       = r_rem - RW'(1);

    // Decode a byte at the start of a character
    always_comb begin
        st_acc = r_acc;
        st_rem = '0;
        if (b == '0) begin
            st_op    = OP_EOT;
            st_phase = PH_IDLE;
        end else if (!b[7]) begin
            st_op    = OP_ASCII;
            st_phase = PH_IDLE;
        end else if (!lead_ok) begin
            st_op    = OP_BAD;
            st_phase = PH_SKIP;
        end else begin
            st_op    = OP_NONE;
            st_phase = PH_COLLECT;
            st_rem   = RW'(len - 4'd1);
            st_acc   = CODE_W'(b & (8'hff >> (len + 4'd1)));
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_rem   = r_rem;
        n_acc   = r_acc;
        op      = OP_NONE;
        data    = CODE_W'(b);
        case (r_phase)
            PH_COLLECT: begin
                if (b[7:6] == 2'b10 && r_rem != '0) begin
                    n_acc = acc_shift;
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = PH_IDLE;
                        data    = acc_shift;
                        op      = (acc_shift > i_max_code_point) ? OP_BAD : OP_VALUE;
                    end
                end else if (b[7]) begin
                    // cut by a non-continuation byte: drop it and skip
                    n_rem   = '0;
                    n_phase = PH_SKIP;
                    op      = OP_BAD;
                end else begin
                    n_rem   = st_rem;
                    n_phase = st_phase;
                    op      = (st_op == OP_EOT) ? OP_CUT_EOT : OP_CUT_ASCII;
                end
            end
            PH_SKIP: begin
                if (!b[7]) begin
                    n_phase = st_phase;
                    n_rem   = st_rem;
                    n_acc   = st_acc;
                    op      = st_op;
                end
            end
            default: begin
                n_phase = st_phase;
                n_rem   = st_rem;
                n_acc   = st_acc;
                op      = st_op;
            end
        endcase
    end

    assign o_push     = accept && (op != OP_NONE);
    assign o_cmd.op   = op;
    assign o_cmd.data = data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_rem   <= '0;
            r_acc   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_acc   <= n_acc;
        end
    end

`ifndef SYNTHESIS
    a_collect_has_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COLLECT) |-> (r_rem != '0))
        else $error("collecting with no continuation bytes left");
    a_idle_no_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_COLLECT) |-> (r_rem == '0))
        else $error("bytes remaining outside a sequence");
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("command pushed into a full queue");
`endif

endmodule

>>> rtl/u8d_queue.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module u8d_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  u8d_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output u8d_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import u8d_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_fill_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count lost a transaction");
`endif

endmodule

>>> rtl/u8d_back.sv
// Back end: expands queued commands into result transactions through an output register.
`timescale 1ns / 1ps

module u8d_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  u8d_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    input  logic [u8d_pkg::CODE_W-1:0]  i_bad_char_code,
    u8d_result_if.source                o_res
);
    import u8d_pkg::*;

    logic              r_valid, r_second;
    logic [CODE_W-1:0] r_cp;
    logic              r_bad, r_eot, r_last;

    logic              load, two, first_of_two;
    logic [CODE_W-1:0] cp;
    logic              bad, eot;

    assign load         = i_valid && (!r_valid || o_res.ready);
    assign two          = (i_cmd.op == OP_CUT_ASCII) || (i_cmd.op == OP_CUT_EOT);
    assign first_of_two = two && !r_second;
    assign o_pop        = load && !first_of_two;

    always_comb begin
        cp  = '0;
        bad = 1'b0;
        eot = 1'b0;
        if (first_of_two) begin
            cp  = i_bad_char_code;
            bad = 1'b1;
        end else begin
            case (i_cmd.op)
                OP_ASCII, OP_VALUE, OP_CUT_ASCII: cp = i_cmd.data;
                OP_EOT, OP_CUT_EOT:               eot = 1'b1;
                OP_BAD: begin
                    cp  = i_bad_char_code;
                    bad = 1'b1;
                end
                default: cp = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= 1'b1;
            r_second <= first_of_two;
        end else if (o_res.ready) begin
            r_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= cp;
            r_bad  <= bad;
            r_eot  <= eot;
            r_last <= !first_of_two;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.code_point  = r_cp;
    assign o_res.is_bad      = r_bad;
    assign o_res.end_of_text = r_eot;
    assign o_res.last        = r_last;

`ifndef SYNTHESIS
    a_second_after_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_valid && r_bad && !r_last))
        else $error("second result pending without a leading bad result");
    a_second_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (i_valid && two))
        else $error("head command lost before its second result");
    a_last_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !first_of_two) |-> o_pop)
        else $error("final result issued without releasing its command");
`endif

endmodule

>>> rtl/utf8_lenient_decoder_core.sv
// Top level of the lenient UTF-8 decoder: configuration registers, front end, queue, back end.
// A result passes through the queue and then the output register after its byte is accepted.
// Throughput: one byte per cycle; the output register emits one result per cycle while the
// receiver is ready, and a byte cut short yields two results, absorbed by a 4-entry queue.
// Input ready drops only while that queue is full; configuration writes complete every cycle.
// Reset (synchronous, active low) returns the decoder to idle, empties the queue and output,
// and restores max_code_point 0x10FFFF and bad_char_code 0xFFFD.
`timescale 1ns / 1ps

module utf8_lenient_decoder_core #(
    parameter int MAX_SEQ_BYTES = u8d_pkg::DEF_MAX_SEQ_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8d_byte_if.sink      i_byte,
    u8d_cfg_if.sink       i_cfg,
    u8d_result_if.source  o_res
);
    import u8d_pkg::*;

    logic [CODE_W-1:0] r_max_code_point;
    logic [CODE_W-1:0] r_bad_char_code;

    logic push, full, q_valid, pop;
    t_cmd push_cmd, head_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_code_point <= RST_MAX_CODE_POINT;
            r_bad_char_code  <= RST_BAD_CHAR_CODE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MAX_CODE_POINT: r_max_code_point <= i_cfg.data;
                REG_BAD_CHAR_CODE:  r_bad_char_code  <= i_cfg.data;
                default:            r_max_code_point <= r_max_code_point;
            endcase
        end
    end

    u8d_front #(
        .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_byte           (i_byte),
        .i_max_code_point (r_max_code_point),
        .i_full           (full),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    u8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    u8d_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_cmd           (head_cmd),
        .o_pop           (pop),
        .i_bad_char_code (r_bad_char_code),
        .o_res           (o_res)
    );

endmodule

>>> tb/sv/utf8_lenient_decoder_core_tb.sv
// Self-checking testbench for the lenient UTF-8 decoder core: directed table, then random streams.
`timescale 1ns / 1ps

module utf8_lenient_decoder_core_tb;
    import u8d_pkg::*;

    localparam int MAX_SEQ     = DEF_MAX_SEQ_BYTES;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;
    localparam int RAND_ITEMS  = 160;   // per register setting, six settings

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COLLECT,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        logic              is_bad;
        logic              end_of_text;
        logic              last;
    } t_char;

    typedef struct {
        bit                is_cfg;
        logic [CODE_W-1:0] cfg_max;
        logic [CODE_W-1:0] cfg_bad;
        logic [BYTE_W-1:0] value;
        bit                typed;
        int                n;
        t_char             c0;
        t_char             c1;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic rx_ready = 1'b0;
    int   send_idle;
    int   recv_idle;
    int   cycle_cnt = 0;
    int   mismatch_cnt = 0;

    // decoder shadow state and register copies
    t_phase            dec_phase;
    logic [2:0]        dec_left;
    logic [CODE_W-1:0] dec_acc;
    logic [CODE_W-1:0] max_cp;
    logic [CODE_W-1:0] bad_cp;
    t_char             step_chars [2];
    int                step_n;
    bit                step_ignored;

    t_char chars_due [$];
    t_char want_char;
    t_row  table_rows [$];

    u8d_byte_if   in_ch ();
    u8d_cfg_if    cfg_ch ();
    u8d_result_if out_ch ();

    assign out_ch.ready = rx_ready;

    utf8_lenient_decoder_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (in_ch),
        .i_cfg   (cfg_ch),
        .o_res   (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    function automatic t_char mk_char(input logic [CODE_W-1:0] cp, input logic bad,
                                      input logic eot, input logic last);
        t_char c;
        c.code_point  = cp;
        c.is_bad      = bad;
        c.end_of_text = eot;
        c.last        = last;
        return c;
    endfunction

    function automatic t_char bad_char();
        return mk_char(bad_cp, 1'b1, 1'b0, 1'b0);
    endfunction

    // Decode a byte as the first of a character; returns 1 when it yields a result.
    function automatic bit start_char(input logic [7:0] b, output t_char c);
        int ones;
        ones = 0;
        c = '0;
        if (b == 8'h00) begin
            dec_phase = PH_IDLE;
            dec_left = '0;
            c.end_of_text = 1'b1;
            return 1'b1;
        end
        if (!b[7]) begin
            dec_phase = PH_IDLE;
            dec_left = '0;
            c.code_point = CODE_W'(b);
            return 1'b1;
        end
        while (ones < 8 && b[7-ones])
            ones++;
        if (ones < 2 || ones > MAX_SEQ) begin
            dec_phase = PH_SKIP;
            dec_left = '0;
            c = bad_char();
            return 1'b1;
        end
        dec_phase = PH_COLLECT;
        dec_left = 3'(ones - 1);
        dec_acc = CODE_W'(b & (8'hFF >> (ones + 1)));
        return 1'b0;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        t_char c;
        step_n = 0;
        step_ignored = 1'b0;
        case (dec_phase)
            PH_COLLECT: begin
                if (b[7:6] == 2'b10 && dec_left != 0) begin
                    dec_acc = {dec_acc[CODE_W-7:0], b[5:0]};
                    dec_left = dec_left - 3'd1;
                    if (dec_left == 0) begin
                        dec_phase = PH_IDLE;
                        if (dec_acc > max_cp)
                            step_chars[0] = bad_char();
                        else
                            step_chars[0] = mk_char(dec_acc, 1'b0, 1'b0, 1'b0);
                        step_n = 1;
                    end
                end else begin
                    // sequence cut short: substitute first, then decode an ASCII or zero byte; a high byte skips
                    step_chars[0] = bad_char();
                    step_n = 1;
                    dec_left = '0;
                    if (b[7])
                        dec_phase = PH_SKIP;
                    else if (start_char(b, c)) begin
                        step_chars[1] = c;
                        step_n = 2;
                    end
                end
            end
            PH_SKIP: begin
                if (b[7])
                    step_ignored = 1'b1;
                else if (start_char(b, c)) begin
                    step_chars[0] = c;
                    step_n = 1;
                end
            end
            default: begin
                if (start_char(b, c)) begin
                    step_chars[0] = c;
                    step_n = 1;
                end
            end
        endcase
        if (step_n > 0)
            step_chars[step_n-1].last = 1'b1;
    endtask

    function automatic t_row pred_row(input logic [7:0] b);
        t_row r;
        r = '{default: '0};
        r.value = b;
        return r;
    endfunction

    function automatic void add_pred(input logic [7:0] b);
        table_rows.push_back(pred_row(b));
    endfunction

    function automatic void add_typed(input logic [7:0] b, input int n, input t_char c0,
                                      input t_char c1);
        t_row r;
        r = pred_row(b);
        r.typed = 1'b1;
        r.n = n;
        r.c0 = c0;
        r.c1 = c1;
        table_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [CODE_W-1:0] mx, input logic [CODE_W-1:0] bd);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg_max = mx;
        r.cfg_bad = bd;
        table_rows.push_back(r);
    endfunction

    // Present one byte, hold it until the transaction, then queue what it decodes to.
    task automatic send_byte(input t_row row);
        while ($urandom_range(0, 99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.byte_value <= row.value;
        do @(posedge i_clk); while (!in_ch.ready);
        decode_byte(row.value);
        if (row.typed) begin
            if (row.n > 0)
                chars_due.push_back(row.c0);
            if (row.n > 1)
                chars_due.push_back(row.c1);
        end else begin
            for (int i = 0; i < step_n; i++)
                chars_due.push_back(step_chars[i]);
        end
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (chars_due.size() != 0)
            @(posedge i_clk);
        // a pending lead byte may still sit in the pipeline
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Leaves valid high so back-to-back writes keep one assignment per step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == REG_MAX_CODE_POINT)
            max_cp = value;
        else
            bad_cp = value;
    endtask

    task automatic apply_setting(input logic [CODE_W-1:0] mx, input logic [CODE_W-1:0] bd);
        wait_idle();
        write_reg(REG_MAX_CODE_POINT, mx);
        write_reg(REG_BAD_CHAR_CODE, bd);
        cfg_ch.valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        rx_ready <= ($urandom_range(0, 99) >= recv_idle);
        if (i_rst_n && out_ch.valid && rx_ready) begin
            if (chars_due.size() == 0) begin
                report_mismatch("unexpected result", 32'(out_ch.code_point), 32'h0);
            end else begin
                want_char = chars_due.pop_front();
                if (out_ch.code_point !== want_char.code_point)
                    report_mismatch("code_point", 32'(out_ch.code_point),
                                    32'(want_char.code_point));
                if (out_ch.is_bad !== want_char.is_bad)
                    report_mismatch("is_bad", 32'(out_ch.is_bad), 32'(want_char.is_bad));
                if (out_ch.end_of_text !== want_char.end_of_text)
                    report_mismatch("end_of_text", 32'(out_ch.end_of_text),
                                    32'(want_char.end_of_text));
                if (out_ch.last !== want_char.last)
                    report_mismatch("last", 32'(out_ch.last), 32'(want_char.last));
            end
        end
    end

    initial begin
        logic [CODE_W-1:0] set_max [6];
        logic [CODE_W-1:0] set_bad [6];
        logic [7:0]        seq [$];
        logic [7:0]        lead;
        int                counted;
        int                len;
        int                cut;
        t_char             none;

        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.byte_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        dec_phase = PH_IDLE;
        dec_left = '0;
        dec_acc = '0;
        max_cp = RST_MAX_CODE_POINT;
        bad_cp = RST_BAD_CHAR_CODE;
        send_idle = 31;
        recv_idle = 77;
        none = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, reset register values first
        add_typed(8'h41, 1, mk_char(31'h41, 1'b0, 1'b0, 1'b1), none);
        add_typed(8'h7F, 1, mk_char(31'h7F, 1'b0, 1'b0, 1'b1), none);
        add_typed(8'h00, 1, mk_char(31'h0, 1'b0, 1'b1, 1'b1), none);
        add_typed(8'h00, 1, mk_char(31'h0, 1'b0, 1'b1, 1'b1), none);
        add_typed(8'h80, 1, mk_char(RST_BAD_CHAR_CODE, 1'b1, 1'b0, 1'b1), none);
        add_typed(8'hBF, 0, none, none);
        add_typed(8'h42, 1, mk_char(31'h42, 1'b0, 1'b0, 1'b1), none);
        add_pred(8'hC3);
        add_pred(8'hA9);
        add_pred(8'hE2);
        add_pred(8'h82);
        add_pred(8'hAC);
        add_typed(8'hE2, 0, none, none);
        add_typed(8'h41, 2, mk_char(RST_BAD_CHAR_CODE, 1'b1, 1'b0, 1'b0),
                  mk_char(31'h41, 1'b0, 1'b0, 1'b1));
        add_typed(8'hC3, 0, none, none);
        add_typed(8'h00, 2, mk_char(RST_BAD_CHAR_CODE, 1'b1, 1'b0, 1'b0),
                  mk_char(31'h0, 1'b0, 1'b1, 1'b1));
        add_typed(8'hC3, 0, none, none);
        add_typed(8'hC3, 1, mk_char(RST_BAD_CHAR_CODE, 1'b1, 1'b0, 1'b1), none);
        add_typed(8'hA9, 0, none, none);
        add_typed(8'h30, 1, mk_char(31'h30, 1'b0, 1'b0, 1'b1), none);
        add_typed(8'hFE, 1, mk_char(RST_BAD_CHAR_CODE, 1'b1, 1'b0, 1'b1), none);
        add_typed(8'hFF, 0, none, none);
        add_typed(8'h00, 1, mk_char(31'h0, 1'b0, 1'b1, 1'b1), none);
        // widest sequence reaches the top code point
        add_cfg(31'h7FFF_FFFF, 31'h0);
        add_pred(8'hFD);
        repeat (4) add_pred(8'hBF);
        add_typed(8'hBF, 1, mk_char(31'h7FFF_FFFF, 1'b0, 1'b0, 1'b1), none);
        // overlong zero passes, anything above zero is substituted
        add_cfg(31'h0, 31'h7FFF_FFFF);
        add_typed(8'hC0, 0, none, none);
        add_typed(8'h80, 1, mk_char(31'h0, 1'b0, 1'b0, 1'b1), none);
        add_typed(8'hC2, 0, none, none);
        add_typed(8'h80, 1, mk_char(31'h7FFF_FFFF, 1'b1, 1'b0, 1'b1), none);

        foreach (table_rows[i]) begin
            if (table_rows[i].is_cfg)
                apply_setting(table_rows[i].cfg_max, table_rows[i].cfg_bad);
            else
                send_byte(table_rows[i]);
        end

        set_max = '{RST_MAX_CODE_POINT, 31'h7FFF_FFFF, 31'h0, 31'h0000_FFFF,
                    CODE_W'($urandom), RST_MAX_CODE_POINT};
        set_bad = '{RST_BAD_CHAR_CODE, 31'h0, 31'h7FFF_FFFF, CODE_W'($urandom),
                    CODE_W'($urandom), RST_BAD_CHAR_CODE};

        for (int k = 0; k < 6; k++) begin
            apply_setting(set_max[k], set_bad[k]);
            send_idle = (k < 2) ? 31 : (k < 4) ? 77 : 0;
            recv_idle = (k < 2) ? 77 : (k < 4) ? 31 : 0;
            counted = 0;
            while (counted < RAND_ITEMS) begin
                seq.delete();
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, MAX_SEQ)
                                                  : $urandom_range(2, 4);
                lead = 8'hFF << (8 - len);
                lead = lead | (8'($urandom) & (8'hFF >> (len + 1)));
                case ($urandom_range(0, 99)) inside
                    [0:39]: begin
                        seq.push_back(lead);
                        for (int j = 1; j < len; j++)
                            seq.push_back(8'h80 | (8'($urandom) & 8'h3F));
                    end
                    [40:64]: seq.push_back(8'($urandom_range(1, 127)));
                    [65:69]: seq.push_back(8'h00);
                    [70:84]: begin
                        // truncated sequence, broken by ASCII, zero or a high non-continuation
                        cut = $urandom_range(1, len - 1);
                        seq.push_back(lead);
                        for (int j = 1; j < cut; j++)
                            seq.push_back(8'h80 | (8'($urandom) & 8'h3F));
                        case ($urandom_range(0, 2))
                            0:       seq.push_back(8'($urandom_range(1, 127)));
                            1:       seq.push_back(8'h00);
                            default: seq.push_back(8'($urandom_range(8'hC0, 8'hFF)));
                        endcase
                    end
                    default: seq.push_back(8'($urandom_range(0, 255)));
                endcase
                foreach (seq[j]) begin
                    send_byte(pred_row(seq[j]));
                    if (!step_ignored)
                        counted++;
                end
            end
        end

        wait_idle();
        if (chars_due.size() != 0)
            report_mismatch("results never seen", 32'(chars_due.size()), 32'h0);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
